>>> rtl/cascade_heater_pid_controller_top_defines.svh
// Assertion macros for the cascade heater PID controller.
// Used by the top level only; no other dependencies.
`ifndef CASCADE_HEATER_PID_CONTROLLER_TOP_DEFINES_SVH
`define CASCADE_HEATER_PID_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CHPID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CHPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHPID_ASSERT(lbl, prop, msg)
`define CHPID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/chpid_pkg.sv
// Shared types and constants of the cascade heater PID controller.
// No dependencies; used by chpid_mac and the top level.
package chpid_pkg;

    localparam int OPA_W  = 17;
    localparam int OPB_W  = 32;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [2:0] CFG_BOX_SETPOINT = 3'd0;
    localparam logic [2:0] CFG_FAN_MODE     = 3'd1;
    localparam logic [2:0] CFG_GAIN_P       = 3'd2;
    localparam logic [2:0] CFG_GAIN_I       = 3'd3;
    localparam logic [2:0] CFG_GAIN_D       = 3'd4;

    localparam logic [1:0] FAN_AUTO = 2'd0;
    localparam logic [1:0] FAN_ON   = 2'd1;

    localparam logic [11:0] TARGET_MAX  = 12'd2400;
    localparam logic [6:0]  DUTY_MAX    = 7'd100;
    localparam logic [6:0]  TREND_SCALE = 7'd60;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

endpackage

>>> rtl/chpid_mac.sv
// Shared multiply-accumulate unit: registered product, then registered accumulator.
// Depends on chpid_pkg for widths and the control struct.
module chpid_mac (
    input  logic                                  i_clk,
    input  chpid_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [chpid_pkg::OPA_W-1:0]    i_op_a,
    input  logic signed [chpid_pkg::OPB_W-1:0]    i_op_b,
    output logic signed [chpid_pkg::PROD_W-1:0]   o_prod,
    output logic signed [chpid_pkg::ACC_W-1:0]    o_acc
);
    logic signed [chpid_pkg::PROD_W-1:0] r_prod;
    logic signed [chpid_pkg::ACC_W-1:0]  r_acc;
    logic signed [chpid_pkg::ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = {{(chpid_pkg::ACC_W - chpid_pkg::PROD_W){r_prod[chpid_pkg::PROD_W-1]}},
                         r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_load) begin
            r_acc <= w_prod_ext;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;
endmodule

>>> rtl/chpid_ring.sv
// Box temperature history ring: one write and one registered read per cycle.
// Per-entry valid bits make never-written entries read as zero after reset.
module chpid_ring #(
    parameter int DEPTH  = 60,
    parameter int ADDR_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic                i_we,
    input  logic signed [15:0]  i_wdata,
    output logic signed [15:0]  o_rdata
);
    logic signed [15:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic signed [15:0] r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_addr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : 16'sd0;
endmodule

>>> rtl/cascade_heater_pid_controller_top.sv
// Cascade heater PID controller: P outer loop, PID inner loop, fan and box trend.
// An accepted input beat passes the error state, the four multiply states and the
// output state, which waits while the output side stalls; no new beat is taken
// until idle again, as the single shared multiplier forms four products in turn.
// Reset (synchronous, active low) restores the register defaults and clears the
// integral, last error, tick counter, ring pointer, ring valid bits and trend.
module cascade_heater_pid_controller_top #(
    parameter int TREND_DEPTH    = 60,
    parameter int TREND_INTERVAL = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] box_temp, [31:16] heater_temp
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [6:0] duty, [7] fan_on,
                                          // [19:8] heater_setpoint, [42:20] trend, rest 0
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    `include "cascade_heater_pid_controller_top_defines.svh"

    localparam int PTR_W = (TREND_DEPTH > 1) ? $clog2(TREND_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_M0   = 3'd2;
    localparam logic [2:0] S_M1   = 3'd3;
    localparam logic [2:0] S_M2   = 3'd4;
    localparam logic [2:0] S_M3   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // configuration
    logic signed [15:0] r_box_setpoint;
    logic [1:0]         r_fan_mode;
    logic [15:0]        r_gain_p, r_gain_i, r_gain_d;

    // controller state
    logic [2:0]          r_state;
    logic signed [31:0]  r_integral;
    logic signed [17:0]  r_prev;
    logic [3:0]          r_tick;
    logic [PTR_W-1:0]    r_ptr;
    logic signed [22:0]  r_trend;

    // per-item working registers
    logic signed [15:0]  r_box, r_heater;
    logic [11:0]         r_target;
    logic signed [17:0]  r_err;
    logic signed [18:0]  r_diff;
    logic signed [16:0]  r_trend_diff;

    logic        r_out_valid;
    logic [47:0] r_out_data;

    // combinational helpers
    logic signed [15:0] w_in_box, w_in_heater;
    logic signed [16:0] w_sp_diff;
    logic signed [19:0] w_t5;
    logic [11:0]        w_target;
    logic signed [17:0] w_err;
    logic signed [32:0] w_isum;
    logic signed [31:0] w_isum_sat;
    logic signed [15:0] w_ring_rd;
    logic               w_accept, w_finish, w_trend_hit;
    logic [3:0]         w_tick_inc;
    logic [PTR_W-1:0]   w_ptr_next;
    logic [38:0]        w_q;
    logic [6:0]         w_duty;
    logic               w_fan;

    chpid_pkg::t_mac_ctl                 w_mac_ctl;
    logic signed [chpid_pkg::OPA_W-1:0]  w_op_a;
    logic signed [chpid_pkg::OPB_W-1:0]  w_op_b;
    logic signed [chpid_pkg::PROD_W-1:0] w_prod;
    logic signed [chpid_pkg::ACC_W-1:0]  w_acc;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_finish        = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    assign w_in_box    = signed'(i_s_axis_tdata[15:0]);
    assign w_in_heater = signed'(i_s_axis_tdata[31:16]);

    // Outer loop: five times the box error, clamped to the heater range.
    always_comb begin
        w_sp_diff = {r_box_setpoint[15], r_box_setpoint} - {w_in_box[15], w_in_box};
        w_t5      = {{1{w_sp_diff[16]}}, w_sp_diff, 2'b00} + {{3{w_sp_diff[16]}}, w_sp_diff};
        if (w_t5[19]) begin
            w_target = 12'd0;
        end else if (w_t5 > signed'({8'b0, chpid_pkg::TARGET_MAX})) begin
            w_target = chpid_pkg::TARGET_MAX;
        end else begin
            w_target = w_t5[11:0];
        end
    end

    // Inner error and saturating integral.
    always_comb begin
        w_err  = signed'({6'b0, r_target}) - {{2{r_heater[15]}}, r_heater};
        w_isum = {r_integral[31], r_integral} + {{15{w_err[17]}}, w_err};
        if (w_isum[32] != w_isum[31]) begin
            w_isum_sat = w_isum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else begin
            w_isum_sat = w_isum[31:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mac_ctl = '0;
        w_op_a    = '0;
        w_op_b    = '0;
        case (r_state)
            S_M0: begin
                w_mac_ctl.mul_en = 1'b1;
                w_op_a = signed'({1'b0, r_gain_p});
                w_op_b = {{14{r_err[17]}}, r_err};
            end
            S_M1: begin
                w_mac_ctl.mul_en   = 1'b1;
                w_mac_ctl.acc_load = 1'b1;
                w_op_a = signed'({1'b0, r_gain_i});
                w_op_b = r_integral;
            end
            S_M2: begin
                w_mac_ctl.mul_en  = 1'b1;
                w_mac_ctl.acc_add = 1'b1;
                w_op_a = signed'({1'b0, r_gain_d});
                w_op_b = {{13{r_diff[18]}}, r_diff};
            end
            S_M3: begin
                w_mac_ctl.mul_en  = 1'b1;
                w_mac_ctl.acc_add = 1'b1;
                w_op_a = signed'({10'b0, chpid_pkg::TREND_SCALE});
                w_op_b = {{15{r_trend_diff[16]}}, r_trend_diff};
            end
            default: begin
            end
        endcase
    end

    chpid_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    assign w_tick_inc  = r_tick + 4'd1;
    assign w_trend_hit = (w_tick_inc >= 4'(TREND_INTERVAL));
    assign w_ptr_next  = (r_ptr == PTR_W'(TREND_DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    chpid_ring #(
        .DEPTH  (TREND_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_ptr),
        .i_we    (w_finish && w_trend_hit),
        .i_wdata (r_box),
        .o_rdata (w_ring_rd)
    );

    // The accumulated sum is in 1/4096 percent; a positive sum shifts down to whole percent.
    always_comb begin
        w_q = w_acc[chpid_pkg::ACC_W-1:12];
        if (w_acc[chpid_pkg::ACC_W-1] || (w_acc == '0)) begin
            w_duty = 7'd0;
        end else if (w_q > {32'b0, chpid_pkg::DUTY_MAX}) begin
            w_duty = chpid_pkg::DUTY_MAX;
        end else begin
            w_duty = w_q[6:0];
        end
        case (r_fan_mode)
            chpid_pkg::FAN_AUTO: w_fan = (w_duty != 7'd0);
            chpid_pkg::FAN_ON:   w_fan = 1'b1;
            default:             w_fan = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_setpoint <= 16'sd400;
            r_fan_mode     <= chpid_pkg::FAN_AUTO;
            r_gain_p       <= 16'd2560;
            r_gain_i       <= 16'd128;
            r_gain_d       <= 16'd26;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                chpid_pkg::CFG_BOX_SETPOINT: r_box_setpoint <= signed'(i_cfg_wdata);
                chpid_pkg::CFG_FAN_MODE:     r_fan_mode     <= i_cfg_wdata[1:0];
                chpid_pkg::CFG_GAIN_P:       r_gain_p       <= i_cfg_wdata;
                chpid_pkg::CFG_GAIN_I:       r_gain_i       <= i_cfg_wdata;
                chpid_pkg::CFG_GAIN_D:       r_gain_d       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integral  <= '0;
            r_prev      <= '0;
            r_tick      <= '0;
            r_ptr       <= '0;
            r_trend     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result may replace the one leaving in the same cycle.
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_integral <= w_isum_sat;
                    r_prev     <= w_err;
                    r_state    <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_OUT;
                S_OUT: begin
                    if (w_finish) begin
                        r_state     <= S_IDLE;
                        if (w_trend_hit) begin
                            r_trend <= w_prod[22:0];
                            r_ptr   <= w_ptr_next;
                            r_tick  <= '0;
                        end else begin
                            r_tick  <= w_tick_inc;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_box    <= w_in_box;
            r_heater <= w_in_heater;
            r_target <= w_target;
        end
        if (r_state == S_ERR) begin
            r_err        <= w_err;
            r_diff       <= {w_err[17], w_err} - {r_prev[17], r_prev};
            r_trend_diff <= {r_box[15], r_box} - {w_ring_rd[15], w_ring_rd};
        end
        if (w_finish) begin
            r_out_data <= {5'b0, (w_trend_hit ? w_prod[22:0] : r_trend),
                           r_target, w_fan, w_duty};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `CHPID_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_s_axis_tready, "accepted a beat but stayed ready")
    `CHPID_ASSERT(a_duty_range, !o_m_axis_tvalid || (o_m_axis_tdata[6:0] <= chpid_pkg::DUTY_MAX), "duty above limit")
    `CHPID_ASSERT(a_target_range, !o_m_axis_tvalid || (o_m_axis_tdata[19:8] <= chpid_pkg::TARGET_MAX), "heater setpoint above limit")
    `CHPID_ASSERT(a_ptr_range, r_ptr <= PTR_W'(TREND_DEPTH - 1), "ring pointer beyond depth")
    `CHPID_ASSERT_NEXT(a_finish_shows_beat, w_finish, o_m_axis_tvalid, "finished item not presented")

endmodule
